// ===== sv/framed_message_ring_buffer_defines.svh =====
// assertion macros for the framed message ring buffer
// expects clk and rst_n in the scope of each use
`ifndef FRAMED_MESSAGE_RING_BUFFER_DEFINES_SVH
`define FRAMED_MESSAGE_RING_BUFFER_DEFINES_SVH

// condition holds on every clock edge out of reset
`define FMRB_ASSERT_HOLD(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define FMRB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define FMRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fmrb_pkg.sv =====
// shared types and codes for the framed message ring buffer
// no dependencies
package fmrb_pkg;

    localparam int CAP_W = 13;
    localparam int LEN_W = 12;

    localparam logic [2:0] CMD_CLEAR   = 3'd0;
    localparam logic [2:0] CMD_RESERVE = 3'd1;
    localparam logic [2:0] CMD_APPEND  = 3'd2;
    localparam logic [2:0] CMD_FINISH  = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;
    localparam logic [2:0] CMD_SKIP    = 3'd5;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_SPACE   = 3'd1;
    localparam logic [2:0] ST_NO_PENDING = 3'd2;
    localparam logic [2:0] ST_EMPTY      = 3'd3;
    localparam logic [2:0] ST_CORRUPT    = 3'd4;
    localparam logic [2:0] ST_ROOM_SHORT = 3'd5;

    localparam logic [7:0] START_MARK = 8'h02;

    typedef struct packed {
        logic [2:0]       command;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] payload_length;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [7:0]       read_byte;
        logic             byte_valid;
        logic             last_of_message;
        logic [LEN_W-1:0] message_length;
        logic [LEN_W-1:0] used_bytes;
        logic [LEN_W-1:0] free_bytes;
    } result_item_t;

endpackage

// ===== sv/fmrb_wrap_add.sv =====
// shared address unit: (base + offset) modulo the ring capacity
// operands stay below the capacity, so one conditional subtract wraps
module fmrb_wrap_add #(
    parameter int PW = 12
) (
    input  logic [PW-1:0] base,
    input  logic [PW-1:0] offset,
    input  logic [PW:0]   cap,
    output logic [PW-1:0] sum
);
    logic [PW:0] raw;
    logic [PW:0] wrapped;

    assign raw     = {1'b0, base} + {1'b0, offset};
    assign wrapped = (raw >= cap) ? (raw - cap) : raw;
    assign sum     = wrapped[PW-1:0];

endmodule

// ===== sv/framed_message_ring_buffer.sv =====
// top level of the framed message ring buffer: sequencer, ring memory, status counts
// depends on fmrb_pkg, fmrb_wrap_add and framed_message_ring_buffer_defines.svh
//
// Usage:
//   Command channel: drive item and raise start; the beat is taken at a rising edge
//   with start high and busy low. Result channel: done is high for exactly one cycle
//   with result valid; the receiver cannot stall it, so it must take every beat.
//   Configuration: cfg_wr_en with cfg_wr_data writes the capacity in use (clamped to
//   8..DEPTH) and clears the ring; write it only while no command is in flight.
//   A new command is taken in the done cycle. The single memory port moves one
//   byte per cycle; one shared wrap adder forms every address and pointer advance.
//   States between S_EXEC and the done state S_RESP, by command:
//     clear, reserve, append, undefined code, failed finish, skip mid-message: none
//     read byte inside a message: S_RD_DATA (one registered memory read)
//     finish: S_HDR_WR per header byte (one written per cycle), then S_COMMIT
//     skip at message start: S_HDR_RD per header byte, S_HDR_LAST, S_HDR_CHK
//     read at message start: those, then S_RD_ISSUE and S_RD_DATA
//   Reset clears pointers and flags and sets the capacity to min(4096, DEPTH); the
//   ring memory is not cleared, its old bytes are never read as committed data.
`include "framed_message_ring_buffer_defines.svh"

module framed_message_ring_buffer #(
    parameter int DEPTH        = 4096,
    parameter int HEADER_BYTES = 3
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  fmrb_pkg::cmd_item_t        item,
    output logic                       done,
    output fmrb_pkg::result_item_t     result,
    input  logic                       cfg_wr_en,
    input  logic [fmrb_pkg::CAP_W-1:0] cfg_wr_data
);
    import fmrb_pkg::*;

    localparam int PW   = $clog2(DEPTH);
    localparam int AW   = ((PW > LEN_W) ? PW : LEN_W) + 1;
    localparam int XW   = AW + 1;
    localparam int IW   = $clog2(HEADER_BYTES);
    localparam int CMPW = (CAP_W > PW + 1) ? CAP_W : PW + 1;
    localparam int CAP_RESET_INT = (DEPTH < 4096) ? DEPTH : 4096;
    localparam logic [PW:0] CAP_RESET = (PW + 1)'(CAP_RESET_INT);
    localparam logic [LEN_W-1:0] LEN_LIMIT = (HEADER_BYTES == 2) ? 12'd255 : 12'd4095;
    localparam logic [IW-1:0] IDX_LAST = IW'(HEADER_BYTES - 1);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_EXEC     = 10'b00_0000_0010,
        S_HDR_WR   = 10'b00_0000_0100,
        S_COMMIT   = 10'b00_0000_1000,
        S_HDR_RD   = 10'b00_0001_0000,
        S_HDR_LAST = 10'b00_0010_0000,
        S_HDR_CHK  = 10'b00_0100_0000,
        S_RD_ISSUE = 10'b00_1000_0000,
        S_RD_DATA  = 10'b01_0000_0000,
        S_RESP     = 10'b10_0000_0000
    } state_t;

    state_t           state_reg, state_next;
    cmd_item_t        item_reg, item_next;
    logic [PW:0]      cap_reg, cap_next;
    logic [PW-1:0]    rp_reg, rp_next;
    logic [PW-1:0]    wp_reg, wp_next;
    logic             pend_act_reg, pend_act_next;
    logic [LEN_W-1:0] pend_len_reg, pend_len_next;
    logic             rd_act_reg, rd_act_next;
    logic [PW-1:0]    rd_rem_reg, rd_rem_next;
    logic [LEN_W-1:0] cur_len_reg, cur_len_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [IW-1:0]    prev_idx_reg, prev_idx_next;
    logic             cap_vld_reg, cap_vld_next;
    logic             mark_ok_reg, mark_ok_next;
    logic [AW-1:0]    acc_reg, acc_next;
    logic             ovf_reg, ovf_next;
    logic [2:0]       status_reg, status_next;
    logic [7:0]       rbyte_reg, rbyte_next;
    logic             valid_reg, valid_next;
    logic             last_reg, last_next;
    logic [LEN_W-1:0] mlen_reg, mlen_next;

    logic [7:0]       mem [DEPTH];
    logic [7:0]       rdata_reg;
    logic             mem_we;
    logic [7:0]       mem_wdata;

    logic             base_wp;
    logic [PW-1:0]    unit_base;
    logic [PW-1:0]    unit_off;
    logic [PW-1:0]    wrap_out;

    logic [PW:0]      used_wide;
    logic [PW-1:0]    used;
    logic [PW:0]      free_wide;
    logic [PW-1:0]    free;
    logic [PW-1:0]    off_hdr_pend;
    logic [PW-1:0]    off_hdr_len;
    logic [PW-1:0]    rem_dec;
    logic [7:0]       hdr_byte;
    logic             corrupt;
    logic [CMPW-1:0]  cfg_ext;

    // committed byte counts from the two pointers
    assign used_wide = (wp_reg >= rp_reg) ? ({1'b0, wp_reg} - {1'b0, rp_reg})
                                          : ({1'b0, wp_reg} + cap_reg - {1'b0, rp_reg});
    assign used      = used_wide[PW-1:0];
    assign free_wide = cap_reg - (PW + 1)'(1) - {1'b0, used};
    assign free      = free_wide[PW-1:0];

    assign off_hdr_pend = PW'(XW'(pend_len_reg) + XW'(HEADER_BYTES));
    assign off_hdr_len  = PW'(XW'(acc_reg) + XW'(HEADER_BYTES));
    assign rem_dec      = (rd_rem_reg != '0) ? (rd_rem_reg - PW'(1)) : rd_rem_reg;
    assign corrupt      = !mark_ok_reg || ovf_reg ||
                          ((XW'(acc_reg) + XW'(HEADER_BYTES)) > XW'(used));
    assign cfg_ext      = CMPW'(cfg_wr_data);

    always_comb
    begin
        if (idx_reg == IDX_LAST)
            hdr_byte = START_MARK;
        else if (idx_reg == IW'(0))
            hdr_byte = pend_len_reg[7:0];
        else if (idx_reg == IW'(1))
            hdr_byte = {4'b0000, pend_len_reg[11:8]};
        else
            hdr_byte = 8'h00;
    end

    assign unit_base = base_wp ? wp_reg : rp_reg;

    fmrb_wrap_add #(
        .PW (PW)
    ) u_wrap (
        .base   (unit_base),
        .offset (unit_off),
        .cap    (cap_reg),
        .sum    (wrap_out)
    );

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        cap_next      = cap_reg;
        rp_next       = rp_reg;
        wp_next       = wp_reg;
        pend_act_next = pend_act_reg;
        pend_len_next = pend_len_reg;
        rd_act_next   = rd_act_reg;
        rd_rem_next   = rd_rem_reg;
        cur_len_next  = cur_len_reg;
        idx_next      = idx_reg;
        prev_idx_next = prev_idx_reg;
        cap_vld_next  = 1'b0;
        mark_ok_next  = mark_ok_reg;
        acc_next      = acc_reg;
        ovf_next      = ovf_reg;
        status_next   = status_reg;
        rbyte_next    = rbyte_reg;
        valid_next    = valid_reg;
        last_next     = last_reg;
        mlen_next     = mlen_reg;
        mem_we        = 1'b0;
        mem_wdata     = item_reg.data_byte;
        base_wp       = 1'b0;
        unit_off      = '0;

        case (state_reg)
            S_IDLE, S_RESP:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = S_EXEC;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_EXEC:
            begin
                status_next = ST_OK;
                rbyte_next  = 8'h00;
                valid_next  = 1'b0;
                last_next   = 1'b0;
                mlen_next   = '0;
                state_next  = S_RESP;
                case (item_reg.command)
                    CMD_CLEAR:
                    begin
                        rp_next       = '0;
                        wp_next       = '0;
                        pend_act_next = 1'b0;
                        pend_len_next = '0;
                        rd_act_next   = 1'b0;
                        rd_rem_next   = '0;
                        cur_len_next  = '0;
                    end
                    CMD_RESERVE:
                    begin
                        if ((XW'(item_reg.payload_length) + XW'(HEADER_BYTES)) > XW'(free))
                        begin
                            status_next = ST_NO_SPACE;
                        end
                        else
                        begin
                            pend_act_next = 1'b1;
                            pend_len_next = '0;
                        end
                    end
                    CMD_APPEND:
                    begin
                        base_wp  = 1'b1;
                        unit_off = off_hdr_pend;
                        if (!pend_act_reg)
                            status_next = ST_NO_PENDING;
                        else if ((pend_len_reg >= LEN_LIMIT) ||
                                 ((XW'(pend_len_reg) + XW'(HEADER_BYTES + 1)) > XW'(free)))
                            status_next = ST_NO_SPACE;
                        else
                        begin
                            mem_we        = 1'b1;
                            pend_len_next = pend_len_reg + LEN_W'(1);
                        end
                    end
                    CMD_FINISH:
                    begin
                        if (!pend_act_reg)
                        begin
                            status_next = ST_NO_PENDING;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_HDR_WR;
                        end
                    end
                    CMD_READ, CMD_SKIP:
                    begin
                        if (rd_act_reg && (item_reg.command == CMD_READ))
                        begin
                            // memory read at the read pointer is issued this cycle
                            state_next = S_RD_DATA;
                        end
                        else if (rd_act_reg)
                        begin
                            unit_off    = rd_rem_reg;
                            rp_next     = wrap_out;
                            rd_rem_next = '0;
                            rd_act_next = 1'b0;
                            last_next   = 1'b1;
                            mlen_next   = cur_len_reg;
                        end
                        else if (used == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (XW'(used) < XW'(HEADER_BYTES))
                        begin
                            status_next = ST_CORRUPT;
                        end
                        else
                        begin
                            idx_next   = IDX_LAST;
                            acc_next   = '0;
                            ovf_next   = 1'b0;
                            state_next = S_HDR_RD;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_HDR_WR:
            begin
                base_wp   = 1'b1;
                unit_off  = PW'(idx_reg);
                mem_we    = 1'b1;
                mem_wdata = hdr_byte;
                if (idx_reg == IDX_LAST)
                    state_next = S_COMMIT;
                else
                    idx_next = idx_reg + IW'(1);
            end

            S_COMMIT:
            begin
                base_wp       = 1'b1;
                unit_off      = off_hdr_pend;
                wp_next       = wrap_out;
                pend_act_next = 1'b0;
                pend_len_next = '0;
                state_next    = S_RESP;
            end

            S_HDR_RD:
            begin
                // marker first, then length bytes from most significant down
                unit_off      = PW'(idx_reg);
                prev_idx_next = idx_reg;
                cap_vld_next  = 1'b1;
                if (idx_reg == IW'(0))
                    state_next = S_HDR_LAST;
                else
                    idx_next = idx_reg - IW'(1);
            end

            S_HDR_LAST:
            begin
                state_next = S_HDR_CHK;
            end

            S_HDR_CHK:
            begin
                state_next = S_RESP;
                if (corrupt)
                begin
                    status_next = ST_CORRUPT;
                end
                else
                begin
                    mlen_next = acc_reg[LEN_W-1:0];
                    if (item_reg.command == CMD_READ)
                    begin
                        if (AW'(item_reg.payload_length) < acc_reg)
                        begin
                            status_next = ST_ROOM_SHORT;
                        end
                        else
                        begin
                            unit_off     = PW'(HEADER_BYTES);
                            rp_next      = wrap_out;
                            cur_len_next = acc_reg[LEN_W-1:0];
                            if (acc_reg == '0)
                            begin
                                // empty message: header consumed, nothing to give
                                last_next = 1'b1;
                            end
                            else
                            begin
                                rd_act_next = 1'b1;
                                rd_rem_next = acc_reg[PW-1:0];
                                state_next  = S_RD_ISSUE;
                            end
                        end
                    end
                    else
                    begin
                        unit_off     = off_hdr_len;
                        rp_next      = wrap_out;
                        cur_len_next = acc_reg[LEN_W-1:0];
                        last_next    = 1'b1;
                    end
                end
            end

            S_RD_ISSUE:
            begin
                state_next = S_RD_DATA;
            end

            S_RD_DATA:
            begin
                unit_off    = PW'(1);
                rp_next     = wrap_out;
                rbyte_next  = rdata_reg;
                valid_next  = 1'b1;
                mlen_next   = cur_len_reg;
                rd_rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    rd_act_next = 1'b0;
                    last_next   = 1'b1;
                end
                state_next = S_RESP;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // header bytes land in the cycle after their read was issued
        if (cap_vld_reg)
        begin
            if (prev_idx_reg == IDX_LAST)
            begin
                mark_ok_next = (rdata_reg == START_MARK);
            end
            else
            begin
                acc_next = {acc_reg[AW-9:0], rdata_reg};
                ovf_next = ovf_reg | (|acc_reg[AW-1 -: 8]);
            end
        end

        if (cfg_wr_en)
        begin
            if (cfg_ext < CMPW'(8))
                cap_next = (PW + 1)'(8);
            else if (cfg_ext > CMPW'(DEPTH))
                cap_next = (PW + 1)'(DEPTH);
            else
                cap_next = (PW + 1)'(cfg_ext);
            rp_next       = '0;
            wp_next       = '0;
            pend_act_next = 1'b0;
            pend_len_next = '0;
            rd_act_next   = 1'b0;
            rd_rem_next   = '0;
            cur_len_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cap_reg      <= CAP_RESET;
            rp_reg       <= '0;
            wp_reg       <= '0;
            pend_act_reg <= 1'b0;
            pend_len_reg <= '0;
            rd_act_reg   <= 1'b0;
            rd_rem_reg   <= '0;
            cur_len_reg  <= '0;
            idx_reg      <= '0;
            prev_idx_reg <= '0;
            cap_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cap_reg      <= cap_next;
            rp_reg       <= rp_next;
            wp_reg       <= wp_next;
            pend_act_reg <= pend_act_next;
            pend_len_reg <= pend_len_next;
            rd_act_reg   <= rd_act_next;
            rd_rem_reg   <= rd_rem_next;
            cur_len_reg  <= cur_len_next;
            idx_reg      <= idx_next;
            prev_idx_reg <= prev_idx_next;
            cap_vld_reg  <= cap_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        mark_ok_reg <= mark_ok_next;
        acc_reg     <= acc_next;
        ovf_reg     <= ovf_next;
        status_reg  <= status_next;
        rbyte_reg   <= rbyte_next;
        valid_reg   <= valid_next;
        last_reg    <= last_next;
        mlen_reg    <= mlen_next;
    end

    // single port ring memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wrap_out] <= mem_wdata;
        rdata_reg <= mem[wrap_out];
    end

    assign busy = !((state_reg == S_IDLE) || (state_reg == S_RESP));
    assign done = (state_reg == S_RESP);

    assign result.status          = status_reg;
    assign result.read_byte       = rbyte_reg;
    assign result.byte_valid      = valid_reg;
    assign result.last_of_message = last_reg;
    assign result.message_length  = mlen_reg;
    assign result.used_bytes      = LEN_W'(used);
    assign result.free_bytes      = LEN_W'(free);

    `FMRB_ASSERT_HOLD(a_ptr_in_ring, (rp_reg < cap_reg) && (wp_reg < cap_reg),
        "pointer beyond ring capacity")
    `FMRB_ASSERT_NEXT(a_accept_busy, start && !busy, busy,
        "accepted command did not make the block busy")
    `FMRB_ASSERT_IMPL(a_active_has_bytes, rd_act_reg, rd_rem_reg != '0,
        "read in progress with no bytes left")
    `FMRB_ASSERT_IMPL(a_byte_only_ok, done && result.byte_valid, result.status == ST_OK,
        "payload byte given with a failing status")
    `FMRB_ASSERT_HOLD(a_pend_limit, pend_len_reg <= LEN_LIMIT,
        "pending length beyond header field range")

endmodule

// ===== tb/sv/tb_framed_message_ring_buffer.sv =====
// self-checking testbench for framed_message_ring_buffer: directed table, then random frames
// depends on fmrb_pkg and the framed_message_ring_buffer rtl; has its own behavioral predictor
module tb_framed_message_ring_buffer;
    timeunit 1ns;
    timeprecision 1ps;

    import fmrb_pkg::*;

    localparam int RING_DEPTH = 4096;
    localparam int HDR        = 3;
    // two or more length bytes cover the whole 12-bit length field
    localparam int LEN_LIMIT  = 4095;

    localparam logic [2:0] CMD_UNDEF_LO = 3'd6;

    typedef struct {
        bit           is_cfg;
        logic [12:0]  cfg_value;
        cmd_item_t    beat;
        bit           typed;
        result_item_t want;
    } table_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    cmd_item_t    item = '0;
    logic         done;
    result_item_t result;
    logic         cfg_wr_en = 1'b0;
    logic [12:0]  cfg_wr_data = '0;

    // predictor state
    logic [7:0]   ring_mem [RING_DEPTH];
    int           cap_cfg = 4096;
    int           rd_pos = 0;
    int           wr_pos = 0;
    bit           pend_on = 1'b0;
    int           pend_len = 0;
    bit           rd_on = 1'b0;
    int           rd_left = 0;
    int           cur_len = 0;

    result_item_t expected_results[$];
    result_item_t predicted_result;
    result_item_t head;
    table_row_t   dir_rows[$];
    int           beats_sent = 0;
    int           mismatches = 0;
    bit           quiet = 1'b0;

    framed_message_ring_buffer #(
        .DEPTH       (RING_DEPTH),
        .HEADER_BYTES(HDR)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .done       (done),
        .result     (result),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int ring_size();
        int c;
        c = cap_cfg;
        if (c < 8) c = 8;
        if (c > RING_DEPTH) c = RING_DEPTH;
        return c;
    endfunction

    function automatic int wrap(int p);
        return p % ring_size();
    endfunction

    function automatic int used_count();
        return (wr_pos + ring_size() - rd_pos) % ring_size();
    endfunction

    function automatic int free_count();
        return ring_size() - 1 - used_count();
    endfunction

    function automatic void drop_all();
        rd_pos = 0;
        wr_pos = 0;
        pend_on = 1'b0;
        pend_len = 0;
        rd_on = 1'b0;
        rd_left = 0;
        cur_len = 0;
    endfunction

    // header at the read position: ok with its length, empty or corrupt
    function automatic logic [2:0] frame_check(output int len);
        int     used;
        int     i;
        longint v;
        used = used_count();
        v = 0;
        len = 0;
        if (used == 0) return ST_EMPTY;
        if (used < HDR) return ST_CORRUPT;
        if (ring_mem[wrap(rd_pos + HDR - 1)] != START_MARK) return ST_CORRUPT;
        for (i = 0; i < HDR - 1; i++)
            v |= longint'(ring_mem[wrap(rd_pos + i)]) << (8 * i);
        if (v + HDR > used) return ST_CORRUPT;
        len = int'(v);
        return ST_OK;
    endfunction

    function automatic result_item_t predict_outcome(cmd_item_t b);
        result_item_t r;
        logic [2:0]   st;
        logic [7:0]   rbyte;
        bit           valid;
        bit           lst;
        bit           fetch;
        int           mlen;
        int           len;
        int           i;
        st = ST_OK;
        rbyte = 8'h00;
        valid = 1'b0;
        lst = 1'b0;
        fetch = 1'b0;
        mlen = 0;
        case (b.command)
            CMD_CLEAR:
                drop_all();
            CMD_RESERVE:
                if (int'(b.payload_length) + HDR > free_count())
                    st = ST_NO_SPACE;
                else
                begin
                    pend_on = 1'b1;
                    pend_len = 0;
                end
            CMD_APPEND:
                if (!pend_on)
                    st = ST_NO_PENDING;
                else if (pend_len >= LEN_LIMIT || pend_len + 1 + HDR > free_count())
                    st = ST_NO_SPACE;
                else
                begin
                    ring_mem[wrap(wr_pos + HDR + pend_len)] = b.data_byte;
                    pend_len++;
                end
            CMD_FINISH:
                if (!pend_on)
                    st = ST_NO_PENDING;
                else
                begin
                    for (i = 0; i < HDR - 1; i++)
                        ring_mem[wrap(wr_pos + i)] = (i < 4) ? 8'((pend_len >> (8 * i)) & 255)
                                                             : 8'h00;
                    ring_mem[wrap(wr_pos + HDR - 1)] = START_MARK;
                    wr_pos = wrap(wr_pos + HDR + pend_len);
                    pend_on = 1'b0;
                    pend_len = 0;
                end
            CMD_READ:
            begin
                fetch = rd_on;
                if (!rd_on)
                begin
                    st = frame_check(len);
                    if (st == ST_OK)
                    begin
                        mlen = len;
                        if (int'(b.payload_length) < len)
                            st = ST_ROOM_SHORT;
                        else
                        begin
                            rd_pos = wrap(rd_pos + HDR);
                            cur_len = len;
                            // an empty frame is consumed with its header alone
                            if (len == 0)
                                lst = 1'b1;
                            else
                            begin
                                rd_on = 1'b1;
                                rd_left = len;
                                fetch = 1'b1;
                            end
                        end
                    end
                end
                if (fetch)
                begin
                    mlen = cur_len;
                    rbyte = ring_mem[wrap(rd_pos)];
                    valid = 1'b1;
                    rd_pos = wrap(rd_pos + 1);
                    if (rd_left > 0) rd_left--;
                    if (rd_left == 0)
                    begin
                        rd_on = 1'b0;
                        lst = 1'b1;
                    end
                end
            end
            CMD_SKIP:
                if (rd_on)
                begin
                    mlen = cur_len;
                    rd_pos = wrap(rd_pos + rd_left);
                    rd_left = 0;
                    rd_on = 1'b0;
                    lst = 1'b1;
                end
                else
                begin
                    st = frame_check(len);
                    if (st == ST_OK)
                    begin
                        mlen = len;
                        cur_len = len;
                        rd_pos = wrap(rd_pos + HDR + len);
                        lst = 1'b1;
                    end
                end
            default: ;
        endcase
        r.status = st;
        r.read_byte = rbyte;
        r.byte_valid = valid;
        r.last_of_message = lst;
        r.message_length = mlen;
        r.used_bytes = used_count();
        r.free_bytes = free_count();
        return r;
    endfunction

    function automatic cmd_item_t mk_beat(logic [2:0] op, logic [7:0] d, logic [11:0] plen);
        cmd_item_t b;
        b.command = op;
        b.data_byte = d;
        b.payload_length = plen;
        return b;
    endfunction

    function automatic void add_step(logic [2:0] op, logic [7:0] d, logic [11:0] plen);
        table_row_t row;
        row = '{1'b0, 13'd0, mk_beat(op, d, plen), 1'b0, '0};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_checked_step(logic [2:0] op, logic [7:0] d, logic [11:0] plen,
                                             logic [2:0] st, logic [7:0] rb, bit v, bit lst,
                                             logic [11:0] ml, logic [11:0] u, logic [11:0] f);
        table_row_t row;
        row.is_cfg = 1'b0;
        row.cfg_value = 13'd0;
        row.beat = mk_beat(op, d, plen);
        row.typed = 1'b1;
        row.want.status = st;
        row.want.read_byte = rb;
        row.want.byte_valid = v;
        row.want.last_of_message = lst;
        row.want.message_length = ml;
        row.want.used_bytes = u;
        row.want.free_bytes = f;
        dir_rows.push_back(row);
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // one command beat; start stays high from the previous beat unless an idle gap falls here
    task automatic send_beat(input cmd_item_t b, input bit typed, input result_item_t want);
        if (!quiet && $urandom_range(99) < 27)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        start <= 1'b1;
        item <= b;
        @(posedge clk);
        while (busy) @(posedge clk);
        predicted_result = predict_outcome(b);
        expected_results.push_back(typed ? want : predicted_result);
        beats_sent++;
    endtask

    // capacity write; only once every result is back and the block is idle
    task automatic write_capacity(input logic [12:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0 || busy) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cap_cfg = v;
        drop_all();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                mismatches++;
            end
            else
            begin
                head = expected_results.pop_front();
                check_field("status", head.status, result.status);
                check_field("read_byte", head.read_byte, result.read_byte);
                check_field("byte_valid", head.byte_valid, result.byte_valid);
                check_field("last_of_message", head.last_of_message, result.last_of_message);
                check_field("message_length", head.message_length, result.message_length);
                check_field("used_bytes", head.used_bytes, result.used_bytes);
                check_field("free_bytes", head.free_bytes, result.free_bytes);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("framed_message_ring_buffer regression: fail");
        $finish;
    end

    initial
    begin
        table_row_t  row;
        int          ph;
        int          goal;
        int          msg_len;
        int          n_app;
        int          pick;
        logic [12:0] cap_val;
        logic [11:0] room;
        logic [2:0]  op;

        // empty ring, writer errors, full-size reserve
        add_checked_step(CMD_READ, 8'h00, 12'd0, ST_EMPTY, 8'h00, 0, 0, 0, 0, 12'd4095);
        add_checked_step(CMD_SKIP, 8'hFF, 12'hFFF, ST_EMPTY, 8'h00, 0, 0, 0, 0, 12'd4095);
        add_checked_step(CMD_APPEND, 8'hAB, 12'd0, ST_NO_PENDING, 8'h00, 0, 0, 0, 0, 12'd4095);
        add_checked_step(CMD_FINISH, 8'h00, 12'd0, ST_NO_PENDING, 8'h00, 0, 0, 0, 0, 12'd4095);
        add_checked_step(CMD_RESERVE, 8'h00, 12'd4095, ST_NO_SPACE, 8'h00, 0, 0, 0, 0, 12'd4095);
        add_checked_step(CMD_RESERVE, 8'h00, 12'd4092, ST_OK, 8'h00, 0, 0, 0, 0, 12'd4095);
        // zero-length frame: header only, consumed by one read
        add_checked_step(CMD_FINISH, 8'h00, 12'd0, ST_OK, 8'h00, 0, 0, 0, 12'd3, 12'd4092);
        add_checked_step(CMD_READ, 8'h00, 12'd0, ST_OK, 8'h00, 0, 1, 0, 0, 12'd4095);
        add_step(CMD_RESERVE, 8'h00, 12'd2);
        add_step(CMD_APPEND, 8'hFF, 12'd0);
        add_step(CMD_APPEND, 8'h00, 12'hFFF);
        add_step(CMD_APPEND, 8'hA5, 12'd0);
        add_checked_step(CMD_FINISH, 8'h00, 12'd0, ST_OK, 8'h00, 0, 0, 0, 12'd6, 12'd4089);
        add_checked_step(CMD_READ, 8'h00, 12'd2, ST_ROOM_SHORT, 8'h00, 0, 0, 12'd3, 12'd6,
                         12'd4089);
        add_step(CMD_READ, 8'h00, 12'd4095);
        // skip in the middle of a frame drops the rest
        add_checked_step(CMD_SKIP, 8'h00, 12'd0, ST_OK, 8'h00, 0, 1, 12'd3, 0, 12'd4095);
        add_checked_step(CMD_UNDEF_LO, 8'hFF, 12'hFFF, ST_OK, 8'h00, 0, 0, 0, 0, 12'd4095);
        add_step(CMD_RESERVE, 8'h00, 12'd1);
        // clear drops the pending frame
        add_checked_step(CMD_CLEAR, 8'h00, 12'd0, ST_OK, 8'h00, 0, 0, 0, 0, 12'd4095);
        add_checked_step(CMD_APPEND, 8'h5A, 12'd0, ST_NO_PENDING, 8'h00, 0, 0, 0, 0, 12'd4095);
        // smallest ring: 7 usable bytes
        row = '{1'b1, 13'd0, '0, 1'b0, '0};
        dir_rows.push_back(row);
        add_checked_step(CMD_RESERVE, 8'h00, 12'd4, ST_OK, 8'h00, 0, 0, 0, 0, 12'd7);
        add_step(CMD_APPEND, 8'h11, 12'd0);
        add_step(CMD_APPEND, 8'h22, 12'd0);
        add_step(CMD_APPEND, 8'h33, 12'd0);
        add_step(CMD_APPEND, 8'h44, 12'd0);
        add_checked_step(CMD_APPEND, 8'h55, 12'd0, ST_NO_SPACE, 8'h00, 0, 0, 0, 0, 12'd7);
        add_checked_step(CMD_FINISH, 8'h00, 12'd0, ST_OK, 8'h00, 0, 0, 0, 12'd7, 12'd0);
        add_checked_step(CMD_RESERVE, 8'h00, 12'd0, ST_NO_SPACE, 8'h00, 0, 0, 0, 12'd7, 12'd0);
        add_checked_step(CMD_SKIP, 8'h00, 12'd0, ST_OK, 8'h00, 0, 1, 12'd4, 0, 12'd7);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_capacity(dir_rows[i].cfg_value);
            else
                send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
        end

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       cap_val = 13'h1FFF;
                1:       cap_val = 13'd8;
                2:       cap_val = 13'($urandom_range(9, 40));
                3:       cap_val = 13'd4096;
                4:       cap_val = 13'($urandom_range(41, 4095));
                default: cap_val = 13'($urandom_range(4097, 8190));
            endcase
            write_capacity(cap_val);
            quiet = (ph == 3);
            goal = beats_sent + 340;
            while (beats_sent < goal)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                begin
                    // writer: reserve, payload, finish, now and then broken
                    msg_len = ($urandom_range(15) == 0) ? $urandom_range(200)
                                                        : $urandom_range(10);
                    if (msg_len > ring_size() / 2) msg_len = $urandom_range(ring_size() / 2);
                    room = ($urandom_range(7) == 0) ? 12'($urandom_range(4095)) : 12'(msg_len);
                    send_beat(mk_beat(CMD_RESERVE, 8'($urandom_range(255)), room), 1'b0, '0);
                    n_app = msg_len;
                    pick = $urandom_range(9);
                    if (pick == 0)
                        n_app += $urandom_range(1, 4);
                    else if (pick == 1 && n_app > 0)
                        n_app = $urandom_range(n_app - 1);
                    repeat (n_app)
                        send_beat(mk_beat(CMD_APPEND, 8'($urandom_range(255)),
                                          12'($urandom_range(4095))), 1'b0, '0);
                    if ($urandom_range(15) != 0)
                        send_beat(mk_beat(CMD_FINISH, 8'($urandom_range(255)),
                                          12'($urandom_range(4095))), 1'b0, '0);
                end
                else if (pick < 75)
                begin
                    // reader: walk one frame to its last byte, sometimes leave with a skip
                    pick = $urandom_range(7);
                    room = (pick == 0) ? 12'($urandom_range(4095)) :
                           (pick == 1) ? 12'd0 : 12'd4095;
                    send_beat(mk_beat(CMD_READ, 8'($urandom_range(255)), room), 1'b0, '0);
                    while (predicted_result.byte_valid && !predicted_result.last_of_message)
                    begin
                        op = ($urandom_range(19) == 0) ? CMD_SKIP : CMD_READ;
                        send_beat(mk_beat(op, 8'($urandom_range(255)),
                                          12'($urandom_range(4095))), 1'b0, '0);
                    end
                end
                else if (pick < 83)
                    send_beat(mk_beat(CMD_SKIP, 8'($urandom_range(255)),
                                      12'($urandom_range(4095))), 1'b0, '0);
                else
                begin
                    op = 3'($urandom_range(7));
                    // clear wipes the ring, keep it rare
                    if (op == CMD_CLEAR && $urandom_range(7) != 0) op = CMD_READ;
                    send_beat(mk_beat(op, 8'($urandom_range(255)), 12'($urandom_range(4095))),
                              1'b0, '0);
                end
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("framed_message_ring_buffer regression: pass");
        else
            $display("framed_message_ring_buffer regression: fail");
        $finish;
    end

endmodule
